// ===== src/cor_pkg.sv =====
// Shared types and constants for the circle outline rasteriser.
`default_nettype none
package cor_pkg;

    localparam int CoordW  = 16;
    localparam int PixW    = 17;
    localparam int RadW    = 4;
    // Walk offsets reach at most the radius and fall to minus one at the end.
    localparam int OfsW    = 5;
    // Decision variable stays within roughly -2 .. 40 for radii up to ten.
    localparam int DecW    = 7;
    localparam int OctW    = 3;
    // One circle emits at most 64 pixels, that is eight walk steps.
    localparam int StepW   = 3;

    localparam logic [RadW-1:0]  RADIUS_RESET = 4'd10;
    localparam logic [StepW-1:0] STEP_LAST    = 3'd7;
    localparam logic [OctW-1:0]  OCT_LAST     = 3'd7;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic last;
    } t_status;

endpackage
`default_nettype wire

// ===== src/cor_ctr_if.sv =====
// Request channel that carries one circle centre.
`default_nettype none
interface cor_ctr_if;
    logic                        valid;
    logic                        ready;
    logic signed [cor_pkg::CoordW-1:0] center_x;
    logic signed [cor_pkg::CoordW-1:0] center_y;

    modport source (output valid, output center_x, output center_y, input ready);
    modport sink   (input valid, input center_x, input center_y, output ready);
endinterface
`default_nettype wire

// ===== src/cor_pix_if.sv =====
// Request channel that carries one outline pixel.
`default_nettype none
interface cor_pix_if;
    logic                            valid;
    logic                            ready;
    logic signed [cor_pkg::PixW-1:0] pixel_x;
    logic signed [cor_pkg::PixW-1:0] pixel_y;
    logic                            last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                    output ready);
endinterface
`default_nettype wire

// ===== src/cor_ctrl.sv =====
// Controller state machine: accepts a centre and sequences the pixel walk.
`default_nettype none
module cor_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cor_pkg::t_status i_status,
    output cor_pkg::t_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = i_status.slot_free;
                if (i_status.slot_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== src/cor_dp.sv =====
// Datapath: radius register, walk variables, octant mirroring and output register.
`default_nettype none
module cor_dp #(
    parameter int MAX_RADIUS = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cor_pkg::RadW-1:0]            i_cfg_wdata,
    input  wire logic signed [cor_pkg::CoordW-1:0]   i_center_x,
    input  wire logic signed [cor_pkg::CoordW-1:0]   i_center_y,
    input  wire logic                                i_out_ready,
    input  wire cor_pkg::t_cmd                       i_cmd,
    output cor_pkg::t_status                         o_status,
    output logic                                     o_out_valid,
    output logic signed [cor_pkg::PixW-1:0]          o_pixel_x,
    output logic signed [cor_pkg::PixW-1:0]          o_pixel_y,
    output logic                                     o_last_pixel
);

    localparam logic [cor_pkg::RadW-1:0] RadMax = cor_pkg::RadW'(MAX_RADIUS);

    logic [cor_pkg::RadW-1:0]              r_radius;
    logic signed [cor_pkg::CoordW-1:0]     r_cx;
    logic signed [cor_pkg::CoordW-1:0]     r_cy;
    logic signed [cor_pkg::OfsW-1:0]       r_x;
    logic signed [cor_pkg::OfsW-1:0]       r_y;
    logic signed [cor_pkg::DecW-1:0]       r_m;
    logic [cor_pkg::OctW-1:0]              r_oct;
    logic [cor_pkg::StepW-1:0]             r_step;
    logic                                  r_out_valid;
    logic signed [cor_pkg::PixW-1:0]       r_px;
    logic signed [cor_pkg::PixW-1:0]       r_py;
    logic                                  r_last;

    logic [cor_pkg::RadW-1:0]              rad_sat;
    logic signed [cor_pkg::DecW-1:0]       rad_d;
    logic signed [cor_pkg::DecW-1:0]       x_d;
    logic signed [cor_pkg::DecW-1:0]       y_d;
    logic signed [cor_pkg::OfsW-1:0]       n_x;
    logic signed [cor_pkg::OfsW-1:0]       n_y;
    logic signed [cor_pkg::DecW-1:0]       n_m;
    logic signed [cor_pkg::OfsW-1:0]       sel_a;
    logic signed [cor_pkg::OfsW-1:0]       sel_b;
    logic signed [cor_pkg::OfsW-1:0]       dx;
    logic signed [cor_pkg::OfsW-1:0]       dy;
    logic                                  walk_end;
    logic                                  slot_free;

    assign rad_sat = (r_radius > RadMax) ? RadMax : r_radius;
    assign rad_d   = signed'(cor_pkg::DecW'(rad_sat));
    assign x_d     = cor_pkg::DecW'(r_x);
    assign y_d     = cor_pkg::DecW'(r_y);

    // Three-way update of the walk.
    always_comb begin
        if (r_m >= (x_d <<< 1)) begin
            n_m = r_m - (x_d <<< 1) - cor_pkg::DecW'(1);
            n_x = r_x + cor_pkg::OfsW'(1);
            n_y = r_y;
        end else if (r_m < ((rad_d - y_d) <<< 1)) begin
            n_m = r_m + (y_d <<< 1) - cor_pkg::DecW'(1);
            n_x = r_x;
            n_y = r_y - cor_pkg::OfsW'(1);
        end else begin
            n_m = r_m + ((y_d - x_d - cor_pkg::DecW'(1)) <<< 1);
            n_x = r_x + cor_pkg::OfsW'(1);
            n_y = r_y - cor_pkg::OfsW'(1);
        end
    end

    assign walk_end = (n_y < n_x) || (r_step == cor_pkg::STEP_LAST);

    // Octant bit 0 swaps the offsets, bit 1 negates the column, bit 2 the row.
    assign sel_a = r_oct[0] ? r_y : r_x;
    assign sel_b = r_oct[0] ? r_x : r_y;
    assign dx    = r_oct[1] ? -sel_a : sel_a;
    assign dy    = r_oct[2] ? -sel_b : sel_b;

    assign slot_free          = !r_out_valid || i_out_ready;
    assign o_status.slot_free = slot_free;
    assign o_status.last      = (r_oct == cor_pkg::OCT_LAST) && walk_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= cor_pkg::RADIUS_RESET;
            r_out_valid <= 1'b0;
            r_oct       <= '0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_oct  <= '0;
                r_step <= '0;
            end else if (i_cmd.step) begin
                r_oct <= r_oct + cor_pkg::OctW'(1);
                if (r_oct == cor_pkg::OCT_LAST) begin
                    r_step <= r_step + cor_pkg::StepW'(1);
                end
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_x  <= '0;
            r_y  <= signed'(cor_pkg::OfsW'(rad_sat));
            r_m  <= rad_d - cor_pkg::DecW'(1);
        end else if (i_cmd.step && (r_oct == cor_pkg::OCT_LAST)) begin
            r_x <= n_x;
            r_y <= n_y;
            r_m <= n_m;
        end
        if (i_cmd.step) begin
            r_px   <= cor_pkg::PixW'(r_cx) + cor_pkg::PixW'(dx);
            r_py   <= cor_pkg::PixW'(r_cy) + cor_pkg::PixW'(dy);
            r_last <= o_status.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_last;

endmodule
`default_nettype wire

// ===== src/circle_outline_rasterizer.sv =====
// Top level of the circle outline rasteriser.
//
//   Channel   Direction  Payload
//   i_ctr     in         center_x, center_y (16-bit signed)
//   o_pix     out        pixel_x, pixel_y (17-bit signed), last_pixel
//   i_cfg_*   in         radius (4 bits), written when i_cfg_we is high
//
// A centre is taken and then expands into 8 pixels per walk step, one
// pixel per cycle from the registered output while the output is not
// stalled; the input stays busy for the whole walk. The pixel sequencer
// is the limit: a new centre is accepted once the last pixel has entered
// the output register.
// Reset is synchronous and active low; the radius returns to ten.
// A stalled output holds the current pixel and the walk waits behind it.
`default_nettype none
module circle_outline_rasterizer #(
    parameter int MAX_RADIUS = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [cor_pkg::RadW-1:0]   i_cfg_wdata,
    cor_ctr_if.sink                         i_ctr,
    cor_pix_if.source                       o_pix
);

    cor_pkg::t_cmd    cmd;
    cor_pkg::t_status status;
    logic             in_ready;

    cor_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_ctr.valid),
        .o_ready  (in_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cor_dp #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_center_x   (i_ctr.center_x),
        .i_center_y   (i_ctr.center_y),
        .i_out_ready  (o_pix.ready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_pix.valid),
        .o_pixel_x    (o_pix.pixel_x),
        .o_pixel_y    (o_pix.pixel_y),
        .o_last_pixel (o_pix.last_pixel)
    );

    assign i_ctr.ready = in_ready;

`ifndef SYNTHESIS
    // Once a centre is taken, no further centre is taken until its walk ends.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctr.valid && i_ctr.ready) |=> !i_ctr.ready)
        else $error("centre accepted while a walk was in progress");

    // A new centre only arrives when no pixel of an earlier circle but its last is pending.
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctr.valid && i_ctr.ready) |-> (!o_pix.valid || o_pix.last_pixel))
        else $error("centre accepted with an unfinished circle in the output");

    // The walk ends by loading the marked last pixel.
    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_ctr.ready) |-> (o_pix.valid && o_pix.last_pixel))
        else $error("walk ended without a last pixel");
`endif

endmodule
`default_nettype wire
